// ----- rtl/core/gpu_load_dvfs_governor_defines.svh -----
// assertion macros shared by the governor rtl
`ifndef GPU_LOAD_DVFS_GOVERNOR_DEFINES_SVH
`define GPU_LOAD_DVFS_GOVERNOR_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define GLDG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define GLDG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/gldg_pkg.sv -----
package gldg_pkg;

	// request kinds on the input tuser
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_SLEEP  = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	// governor modes
	localparam logic [1:0] MODE_PERF = 2'd0;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_UP_THR   = 3'd1;
	localparam logic [2:0] REG_DOWN_THR = 3'd2;
	localparam logic [2:0] REG_UP_DIFF  = 3'd3;
	localparam logic [2:0] REG_PERIOD   = 3'd4;
	localparam logic [2:0] REG_FAST     = 3'd5;
	localparam logic [2:0] REG_SLOW     = 3'd6;

	// register reset values
	localparam logic [1:0]  RST_MODE     = 2'd2;
	localparam logic [6:0]  RST_UP_THR   = 7'd60;
	localparam logic [6:0]  RST_DOWN_THR = 7'd25;
	localparam logic [6:0]  RST_UP_DIFF  = 7'd10;
	localparam logic [15:0] RST_PERIOD   = 16'd100;
	localparam logic [3:0]  RST_FAST     = 4'd0;
	localparam logic [3:0]  RST_SLOW     = 4'd4;

	// nominal reset level, clamped to the level count where used
	localparam int LEVEL_RESET_NOM = 4;

	// load arithmetic
	localparam logic [6:0]  PCT_SCALE = 7'd100;
	localparam logic [7:0]  LOAD_SAT  = 8'hFF;
	localparam logic [15:0] WIN_MAX   = 16'hFFFF;
	// divider runs quotient bits 8 down to 0, bit 8 flags saturation
	localparam logic [3:0]  DIV_FIRST = 4'd8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [6:0]  up_thr;
		logic [6:0]  down_thr;
		logic [6:0]  up_diff;
		logic [15:0] period;
		logic [3:0]  fast;
		logic [3:0]  slow;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPLY,
		S_MUL,
		S_TDIV,
		S_LLOAD,
		S_LDIV,
		S_DECIDE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic mul;
		logic div_step;
		logic div_reload;
		logic decide;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic eval_go;
		logic div_last;
	} sts_t;

endpackage

// ----- rtl/core/gldg_ctrl.sv -----
module gldg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            m_tready,
	input  gldg_pkg::sts_t  sts,
	output logic            s_tready,
	output logic            m_tvalid,
	output gldg_pkg::cmd_t  cmd
);

	gldg_pkg::state_t state_q;
	gldg_pkg::state_t state_nxt;
	logic             m_tvalid_q;
	logic             out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gldg_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gldg_pkg::S_IDLE: begin
				if (s_tvalid) state_nxt = gldg_pkg::S_APPLY;
			end
			gldg_pkg::S_APPLY: begin
				state_nxt = sts.eval_go ? gldg_pkg::S_MUL : gldg_pkg::S_DONE;
			end
			gldg_pkg::S_MUL: begin
				state_nxt = gldg_pkg::S_TDIV;
			end
			gldg_pkg::S_TDIV: begin
				if (sts.div_last) state_nxt = gldg_pkg::S_LLOAD;
			end
			gldg_pkg::S_LLOAD: begin
				state_nxt = gldg_pkg::S_LDIV;
			end
			gldg_pkg::S_LDIV: begin
				if (sts.div_last) state_nxt = gldg_pkg::S_DECIDE;
			end
			gldg_pkg::S_DECIDE: begin
				state_nxt = gldg_pkg::S_DONE;
			end
			gldg_pkg::S_DONE: begin
				if (out_free) state_nxt = gldg_pkg::S_IDLE;
			end
			default: begin
				state_nxt = gldg_pkg::S_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			gldg_pkg::S_IDLE:   cmd.capture    = s_tvalid;
			gldg_pkg::S_APPLY:  cmd.apply      = 1'b1;
			gldg_pkg::S_MUL:    cmd.mul        = 1'b1;
			gldg_pkg::S_TDIV:   cmd.div_step   = 1'b1;
			gldg_pkg::S_LLOAD:  cmd.div_reload = 1'b1;
			gldg_pkg::S_LDIV:   cmd.div_step   = 1'b1;
			gldg_pkg::S_DECIDE: cmd.decide     = 1'b1;
			gldg_pkg::S_DONE:   cmd.out_load   = out_free;
			default:            cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == gldg_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

// ----- rtl/core/gldg_dp.sv -----
module gldg_dp #(
	parameter int LEVEL_COUNT = 16,
	parameter int BUSY_FLOOR  = 5000
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gldg_pkg::cmd_t  cmd,
	input  gldg_pkg::cfg_t  cfg,
	input  logic [1:0]      in_req,
	input  logic [31:0]     in_busy,
	input  logic [31:0]     in_total,
	output gldg_pkg::sts_t  sts,
	output logic [3:0]      out_level,
	output logic [7:0]      out_load,
	output logic            out_changed,
	output logic            out_eval
);

	localparam logic [3:0] LVL_MAX = 4'(LEVEL_COUNT - 1);
	localparam logic [3:0] LVL_RST = 4'((LEVEL_COUNT - 1 < gldg_pkg::LEVEL_RESET_NOM) ?
		(LEVEL_COUNT - 1) : gldg_pkg::LEVEL_RESET_NOM);
	localparam logic [31:0] FLOOR = 32'(BUSY_FLOOR);

	function automatic logic [3:0] clamp_lvl(input logic [3:0] v);
		return (v > LVL_MAX) ? LVL_MAX : v;
	endfunction

	// governor state
	logic [3:0]  level_q;
	logic [31:0] busy_acc_q;
	logic [31:0] total_acc_q;
	logic [15:0] window_q;
	logic [7:0]  last_load_q;

	// item registers
	logic [1:0]  req_q;
	logic [31:0] busy_in_q;
	logic [31:0] total_in_q;
	logic [3:0]  before_q;
	logic        eval_q;

	// multiplier and divider
	logic [38:0] prod_q;
	logic [39:0] rem_q;
	logic [39:0] dsh_q;
	logic [8:0]  quot_q;
	logic [3:0]  cnt_q;
	logic [6:0]  thr_div_q;

	logic [32:0] busy_sum;
	logic [32:0] total_sum;
	logic [31:0] busy_new;
	logic [31:0] total_new;
	logic        div_ge;
	logic [3:0]  lvl_div;
	logic [3:0]  fast;
	logic [3:0]  slow;
	logic [6:0]  thr;
	logic [7:0]  load;

	// saturating accumulate
	assign busy_sum  = {1'b0, busy_acc_q} + {1'b0, busy_in_q};
	assign total_sum = {1'b0, total_acc_q} + {1'b0, total_in_q};
	assign busy_new  = busy_sum[32] ? '1 : busy_sum[31:0];
	assign total_new = total_sum[32] ? '1 : total_sum[31:0];

	assign sts.eval_go = (req_q == gldg_pkg::REQ_SAMPLE) && (cfg.mode != gldg_pkg::MODE_PERF) &&
		(total_in_q != '0) && (busy_new >= FLOOR) && (window_q >= cfg.period);
	assign sts.div_last = (cnt_q == '0);

	assign div_ge  = (rem_q >= dsh_q);
	// zero level: divide by one, which leaves the up threshold itself
	assign lvl_div = (level_q == '0) ? 4'd1 : level_q;

	assign fast = clamp_lvl(cfg.fast);
	assign slow = clamp_lvl(cfg.slow);
	assign load = quot_q[8] ? gldg_pkg::LOAD_SAT : quot_q[7:0];

	always_comb begin
		thr = cfg.up_thr;
		if (level_q == slow) begin
			thr = thr_div_q;
		end else if (level_q < slow && level_q > fast) begin
			thr = (cfg.up_thr > cfg.up_diff) ? (cfg.up_thr - cfg.up_diff) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LVL_RST;
			busy_acc_q  <= '0;
			total_acc_q <= '0;
			window_q    <= gldg_pkg::WIN_MAX;
			last_load_q <= '0;
		end else if (cmd.apply) begin
			case (req_q)
				gldg_pkg::REQ_SAMPLE: begin
					if (cfg.mode != gldg_pkg::MODE_PERF) begin
						busy_acc_q  <= busy_new;
						total_acc_q <= total_new;
					end
				end
				gldg_pkg::REQ_SLEEP: begin
					level_q     <= slow;
					busy_acc_q  <= '0;
					total_acc_q <= '0;
					window_q    <= '0;
				end
				gldg_pkg::REQ_TICK: begin
					if (window_q != gldg_pkg::WIN_MAX) window_q <= window_q + 16'd1;
				end
				default: begin
				end
			endcase
		end else if (cmd.decide) begin
			last_load_q <= load;
			if (load > {1'b0, thr}) begin
				if (level_q > fast) level_q <= level_q - 4'd1;
			end else if (load < {1'b0, cfg.down_thr}) begin
				if (level_q < slow) level_q <= level_q + 4'd1;
			end
			busy_acc_q  <= '0;
			total_acc_q <= '0;
			window_q    <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= in_req;
			busy_in_q  <= in_busy;
			total_in_q <= in_total;
			before_q   <= level_q;
			eval_q     <= 1'b0;
		end
		if (cmd.decide) eval_q <= 1'b1;

		if (cmd.mul) begin
			prod_q <= 39'(busy_acc_q) * 39'(gldg_pkg::PCT_SCALE);
			rem_q  <= 40'(cfg.up_thr);
			dsh_q  <= {28'd0, lvl_div, 8'd0};
			quot_q <= '0;
			cnt_q  <= gldg_pkg::DIV_FIRST;
		end else if (cmd.div_reload) begin
			thr_div_q <= quot_q[6:0];
			rem_q     <= {1'b0, prod_q};
			dsh_q     <= {total_acc_q, 8'd0};
			quot_q    <= '0;
			cnt_q     <= gldg_pkg::DIV_FIRST;
		end else if (cmd.div_step) begin
			if (div_ge) rem_q <= rem_q - dsh_q;
			quot_q <= {quot_q[7:0], div_ge};
			dsh_q  <= dsh_q >> 1;
			cnt_q  <= cnt_q - 4'd1;
		end

		if (cmd.out_load) begin
			out_level   <= level_q;
			out_load    <= last_load_q;
			out_changed <= (level_q != before_q);
			out_eval    <= eval_q;
		end
	end

endmodule

// ----- rtl/core/gpu_load_dvfs_governor.sv -----
// channel   dir  signals                              beat content
// s_axis    in   s_tvalid s_tready s_tdata s_tuser    one request: sample, sleep or tick
// m_axis    out  m_tvalid m_tready m_tdata            one result beat per request
// apb cfg   in   psel penable pwrite paddr pwdata     seven governor registers at 4*i
//
// one request at a time: sleep, tick or a sample that does not evaluate goes from accept
// to result without the divider; an evaluating sample runs the two 9-step restoring
// divisions in the shared divider
// reset sets level to nominal, window to max, clears accumulators and load
// a stalled result beat holds the next request in its final state only;
// s_tready is high whenever the controller is idle
`include "gpu_load_dvfs_governor_defines.svh"

module gpu_load_dvfs_governor #(
	parameter int LEVEL_COUNT = 16,
	parameter int BUSY_FLOOR  = 5000
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] busy_us, [63:32] total_us
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] power_level, [11:4] load_percent,
	                               // [12] level_changed, [13] evaluated, [15:14] zero
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [3:0] LVL_MAX = 4'(LEVEL_COUNT - 1);

	gldg_pkg::cfg_t cfg_q;
	gldg_pkg::cmd_t cmd;
	gldg_pkg::sts_t sts;

	logic       cfg_wr;
	logic [2:0] reg_idx;
	logic [3:0] out_level;
	logic [7:0] out_load;
	logic       out_changed;
	logic       out_eval;

	// register file, written on the apb access phase
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= gldg_pkg::RST_MODE;
			cfg_q.up_thr   <= gldg_pkg::RST_UP_THR;
			cfg_q.down_thr <= gldg_pkg::RST_DOWN_THR;
			cfg_q.up_diff  <= gldg_pkg::RST_UP_DIFF;
			cfg_q.period   <= gldg_pkg::RST_PERIOD;
			cfg_q.fast     <= gldg_pkg::RST_FAST;
			cfg_q.slow     <= gldg_pkg::RST_SLOW;
		end else if (cfg_wr) begin
			case (reg_idx)
				gldg_pkg::REG_MODE:     cfg_q.mode     <= pwdata[1:0];
				gldg_pkg::REG_UP_THR:   cfg_q.up_thr   <= pwdata[6:0];
				gldg_pkg::REG_DOWN_THR: cfg_q.down_thr <= pwdata[6:0];
				gldg_pkg::REG_UP_DIFF:  cfg_q.up_diff  <= pwdata[6:0];
				gldg_pkg::REG_PERIOD:   cfg_q.period   <= pwdata[15:0];
				gldg_pkg::REG_FAST:     cfg_q.fast     <= pwdata[3:0];
				gldg_pkg::REG_SLOW:     cfg_q.slow     <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// read-back mux, unused addresses read zero
	always_comb begin
		case (reg_idx)
			gldg_pkg::REG_MODE:     prdata = 32'(cfg_q.mode);
			gldg_pkg::REG_UP_THR:   prdata = 32'(cfg_q.up_thr);
			gldg_pkg::REG_DOWN_THR: prdata = 32'(cfg_q.down_thr);
			gldg_pkg::REG_UP_DIFF:  prdata = 32'(cfg_q.up_diff);
			gldg_pkg::REG_PERIOD:   prdata = 32'(cfg_q.period);
			gldg_pkg::REG_FAST:     prdata = 32'(cfg_q.fast);
			gldg_pkg::REG_SLOW:     prdata = 32'(cfg_q.slow);
			default:                prdata = '0;
		endcase
	end

	// sequencer: accept, apply, multiply, two divisions, decide, result
	gldg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	// accumulators, level state, shared divider and result register
	gldg_dp #(
		.LEVEL_COUNT (LEVEL_COUNT),
		.BUSY_FLOOR  (BUSY_FLOOR)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg_q),
		.in_req      (s_tuser),
		.in_busy     (s_tdata[31:0]),
		.in_total    (s_tdata[63:32]),
		.sts         (sts),
		.out_level   (out_level),
		.out_load    (out_load),
		.out_changed (out_changed),
		.out_eval    (out_eval)
	);

	assign m_tdata = {2'b00, out_eval, out_changed, out_load, out_level};

	// only one request in flight
	`GLDG_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second request taken while busy")
	// loading a result always presents a beat
	`GLDG_ASSERT_NEXT(a_out_load_valid, cmd.out_load, m_tvalid, "result loaded but not presented")
	// level never leaves the level range
	`GLDG_ASSERT_NOW(a_level_range, m_tvalid, m_tdata[3:0] <= LVL_MAX, "power level out of range")

endmodule
